FILE: sv/cdn_pkg.sv
// Types, constants and tables shared by the calendar day number converter.
package cdn_pkg;

	typedef struct packed {
		logic        mode;
		logic [13:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [22:0] in_julian;
	} cdn_req_t;

	typedef struct packed {
		logic [22:0] day_number;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic        valid_res;
	} cdn_rsp_t;

	localparam logic MODE_TO_NUMBER = 1'b0;
	localparam logic MODE_TO_DATE   = 1'b1;

	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	localparam logic [13:0] MIN_YEAR_RST = 14'd1753;
	localparam logic [13:0] MAX_YEAR_RST = 14'd9999;

	localparam logic [22:0] JD_EPOCH = 23'd1721119;
	localparam logic [22:0] JD_FIRST = 23'd1721426;
	localparam logic [22:0] JD_LAST  = 23'd5373484;

	localparam logic [17:0] C_146097 = 18'd146097;
	localparam logic [10:0] C_1461   = 11'd1461;
	localparam logic [7:0]  C_153    = 8'd153;
	localparam logic [6:0]  C_100    = 7'd100;

	// Reciprocals: floor(x / d) == (x * (floor(2^k / d) + 1)) >> k for x < 2^n,
	// with k = n + ceil(log2(d)).
	localparam int DIV100_K    = 21;
	localparam int DIV146097_K = 42;
	localparam int DIV1461_K   = 29;
	localparam int DIV153_K    = 19;
	localparam int DIV5_K      = 11;

	localparam logic [14:0] DIV100_M    = 15'((64'd1 << DIV100_K) / 100 + 1);
	localparam logic [24:0] DIV146097_M = 25'((64'd1 << DIV146097_K) / 146097 + 1);
	localparam logic [18:0] DIV1461_M   = 19'((64'd1 << DIV1461_K) / 1461 + 1);
	localparam logic [11:0] DIV153_M    = 12'((64'd1 << DIV153_K) / 153 + 1);
	localparam logic [8:0]  DIV5_M      = 9'((64'd1 << DIV5_K) / 5 + 1);

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days before the month, counted from March: (153 * m + 2) / 5.
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] off;
		case (mp)
			4'd0:    off = 9'd0;
			4'd1:    off = 9'd31;
			4'd2:    off = 9'd61;
			4'd3:    off = 9'd92;
			4'd4:    off = 9'd122;
			4'd5:    off = 9'd153;
			4'd6:    off = 9'd184;
			4'd7:    off = 9'd214;
			4'd8:    off = 9'd245;
			4'd9:    off = 9'd275;
			4'd10:   off = 9'd306;
			4'd11:   off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

FILE: sv/calendar_day_number_converter.sv
// Eight-stage pipeline converting Gregorian dates to Julian day numbers and back.
// The converter accepts one word per clock while req_stall is low and returns
// the results in order. Each stage holds one word and moves on whenever the
// stage after it is empty or moving, so bubbles close up behind a stalled
// output and new words keep entering until the pipeline is full. All divisions
// are by constants and are done as reciprocal multiplies, spread over the
// stages with at most three in a stage. The year bounds are written through the
// APB port at byte addresses 0 and 4 and are used only when a date enters the
// first stage.
module calendar_day_number_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  cdn_pkg::cdn_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cdn_pkg::cdn_rsp_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [13:0] min_year_q, max_year_q;

	logic load1, load2, load3, load4, load5, load6, load7, load8;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic        mode_s1, mode_s2, mode_s3, mode_s4, mode_s5, mode_s6, mode_s7;
	logic [22:0] jd_s1, jd_s2, jd_s3, jd_s4;
	logic        span_s1, span_s2, span_s3, span_s4;
	logic [22:0] num_s5, num_s6, num_s7;
	logic        ok_s5, ok_s6, ok_s7;

	logic [23:0] t_s1, t_s2;
	logic [6:0]  y4_s2, y4_s3, y4_s4;
	logic [17:0] u_s3, u_s4;
	logic [6:0]  jj_s4;
	logic [10:0] mv_s5, mv_s6;
	logic [13:0] yy0_s5, yy0_s6;
	logic [3:0]  m_s6;
	logic [7:0]  dd2_s7;
	logic [3:0]  mo_s7;
	logic [13:0] yy_s7;

	logic [13:0] yr_s1, yr_s2, yp_s1, yp_s2;
	logic [3:0]  mp_s1, mp_s2, mp_s3, mon_s1, mon_s2;
	logic [4:0]  day_s1, day_s2, day_s3, day_s4;
	logic        base_ok_s1, base_ok_s2, ok0_s3, ok0_s4;
	logic [7:0]  q_yr_s2, q_yp_s2, c_s3;
	logic [6:0]  ya_s3;
	logic [22:0] a_s4;
	logic [15:0] b_s4;
	logic [8:0]  e_s4;

	cdn_pkg::cdn_rsp_t rsp_s8;

	// Configuration port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= cdn_pkg::MIN_YEAR_RST;
			max_year_q <= cdn_pkg::MAX_YEAR_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				cdn_pkg::REG_MIN_YEAR: min_year_q <= pwdata[13:0];
				cdn_pkg::REG_MAX_YEAR: max_year_q <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			cdn_pkg::REG_MIN_YEAR: prdata = {18'd0, min_year_q};
			cdn_pkg::REG_MAX_YEAR: prdata = {18'd0, max_year_q};
			default:               prdata = 32'd0;
		endcase
	end

	// Flow control: a stage loads when it is empty or its word moves on.
	assign load8 = !v_s8 || !rsp_stall;
	assign load7 = !v_s7 || load8;
	assign load6 = !v_s6 || load7;
	assign load5 = !v_s5 || load6;
	assign load4 = !v_s4 || load5;
	assign load3 = !v_s3 || load4;
	assign load2 = !v_s2 || load3;
	assign load1 = !v_s1 || load2;

	assign req_stall = !load1;
	assign rsp_valid = v_s8;
	assign rsp       = rsp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (load1) v_s1 <= req_valid;
			if (load2) v_s2 <= v_s1;
			if (load3) v_s3 <= v_s2;
			if (load4) v_s4 <= v_s3;
			if (load5) v_s5 <= v_s4;
			if (load6) v_s6 <= v_s5;
			if (load7) v_s7 <= v_s6;
			if (load8) v_s8 <= v_s7;
		end
	end

	// Stage 1: offsets, range checks, March-based month and year.
	logic [22:0] j_c1;
	assign j_c1 = req.in_julian - cdn_pkg::JD_EPOCH;

	always_ff @(posedge clk) begin
		if (load1) begin
			mode_s1    <= req.mode;
			jd_s1      <= req.in_julian;
			span_s1    <= (req.in_julian >= cdn_pkg::JD_FIRST)
			              && (req.in_julian <= cdn_pkg::JD_LAST);
			t_s1       <= {j_c1[21:0], 2'b00} - 24'd1;
			yr_s1      <= req.in_year;
			yp_s1      <= (req.in_month > 4'd2) ? req.in_year : req.in_year - 14'd1;
			mp_s1      <= (req.in_month > 4'd2) ? req.in_month - 4'd3 : req.in_month + 4'd9;
			mon_s1     <= req.in_month;
			day_s1     <= req.in_day;
			base_ok_s1 <= (req.in_day != 5'd0) && (req.in_month >= 4'd1)
			              && (req.in_month <= 4'd12) && (req.in_year != 14'd0)
			              && (req.in_year >= min_year_q) && (req.in_year <= max_year_q);
		end
	end

	// Stage 2: quotients by 146097 and by 100.
	logic [48:0] prod_y4_c2;
	logic [28:0] prod_yr_c2, prod_yp_c2;
	assign prod_y4_c2 = 49'(t_s1) * 49'(cdn_pkg::DIV146097_M);
	assign prod_yr_c2 = 29'(yr_s1) * 29'(cdn_pkg::DIV100_M);
	assign prod_yp_c2 = 29'(yp_s1) * 29'(cdn_pkg::DIV100_M);

	always_ff @(posedge clk) begin
		if (load2) begin
			mode_s2    <= mode_s1;
			jd_s2      <= jd_s1;
			span_s2    <= span_s1;
			t_s2       <= t_s1;
			y4_s2      <= prod_y4_c2[48:42];
			q_yr_s2    <= prod_yr_c2[28:21];
			q_yp_s2    <= prod_yp_c2[28:21];
			yr_s2      <= yr_s1;
			yp_s2      <= yp_s1;
			mp_s2      <= mp_s1;
			mon_s2     <= mon_s1;
			day_s2     <= day_s1;
			base_ok_s2 <= base_ok_s1;
		end
	end

	// Stage 3: remainders, leap year and day-of-month check.
	logic [23:0] j1_c3;
	logic [13:0] r100_c3, ya_c3;
	logic        leap_c3;
	logic [4:0]  lim_c3;
	assign j1_c3   = t_s2 - 24'(y4_s2) * 24'(cdn_pkg::C_146097);
	assign r100_c3 = yr_s2 - 14'(q_yr_s2) * 14'(cdn_pkg::C_100);
	assign ya_c3   = yp_s2 - 14'(q_yp_s2) * 14'(cdn_pkg::C_100);
	assign leap_c3 = ((yr_s2[1:0] == 2'd0) && (r100_c3 != 14'd0))
	                 || ((r100_c3 == 14'd0) && (q_yr_s2[1:0] == 2'd0));
	assign lim_c3  = cdn_pkg::month_len(mon_s2)
	                 + {4'd0, leap_c3 && (mon_s2 == 4'd2)};

	always_ff @(posedge clk) begin
		if (load3) begin
			mode_s3 <= mode_s2;
			jd_s3   <= jd_s2;
			span_s3 <= span_s2;
			u_s3    <= {j1_c3[17:2], 2'b11};
			y4_s3   <= y4_s2;
			c_s3    <= q_yp_s2;
			ya_s3   <= ya_c3[6:0];
			mp_s3   <= mp_s2;
			day_s3  <= day_s2;
			ok0_s3  <= base_ok_s2 && (day_s2 <= lim_c3);
		end
	end

	// Stage 4: quotient by 1461 and the century, year and month terms.
	logic [36:0] prod_jj_c4;
	logic [24:0] prod_a_c4;
	logic [17:0] prod_b_c4;
	assign prod_jj_c4 = 37'(u_s3) * 37'(cdn_pkg::DIV1461_M);
	assign prod_a_c4  = 25'(c_s3) * 25'(cdn_pkg::C_146097);
	assign prod_b_c4  = 18'(ya_s3) * 18'(cdn_pkg::C_1461);

	always_ff @(posedge clk) begin
		if (load4) begin
			mode_s4 <= mode_s3;
			jd_s4   <= jd_s3;
			span_s4 <= span_s3;
			u_s4    <= u_s3;
			y4_s4   <= y4_s3;
			jj_s4   <= prod_jj_c4[35:29];
			a_s4    <= prod_a_c4[24:2];
			b_s4    <= prod_b_c4[17:2];
			e_s4    <= cdn_pkg::month_offset(mp_s3);
			day_s4  <= day_s3;
			ok0_s4  <= ok0_s3;
		end
	end

	// Stage 5: day of year and the day number sum.
	logic [17:0] d2_c5;
	logic [11:0] d3w_c5;
	logic [8:0]  d3_c5;
	logic [23:0] sum_c5;
	assign d2_c5  = u_s4 - 18'(jj_s4) * 18'(cdn_pkg::C_1461);
	assign d3w_c5 = 12'(d2_c5[10:0]) + 12'd4;
	assign d3_c5  = d3w_c5[10:2];
	assign sum_c5 = 24'(a_s4) + 24'(b_s4) + 24'(e_s4) + 24'(day_s4)
	                + 24'(cdn_pkg::JD_EPOCH);

	always_ff @(posedge clk) begin
		if (load5) begin
			mode_s5 <= mode_s4;
			mv_s5   <= {d3_c5, 2'b00} + 11'(d3_c5) - 11'd3;
			yy0_s5  <= 14'(y4_s4) * 14'(cdn_pkg::C_100) + 14'(jj_s4);
			if (mode_s4 == cdn_pkg::MODE_TO_DATE) begin
				num_s5 <= jd_s4;
				ok_s5  <= span_s4;
			end else begin
				num_s5 <= ok0_s4 ? sum_c5[22:0] : 23'd0;
				ok_s5  <= ok0_s4;
			end
		end
	end

	// Stage 6: March-based month.
	logic [22:0] prod_m_c6;
	assign prod_m_c6 = 23'(mv_s5) * 23'(cdn_pkg::DIV153_M);

	always_ff @(posedge clk) begin
		if (load6) begin
			mode_s6 <= mode_s5;
			num_s6  <= num_s5;
			ok_s6   <= ok_s5;
			m_s6    <= prod_m_c6[22:19];
			mv_s6   <= mv_s5;
			yy0_s6  <= yy0_s5;
		end
	end

	// Stage 7: day remainder and the shift back to a January-based calendar.
	logic [10:0] dd2_c7;
	assign dd2_c7 = mv_s6 - 11'(m_s6) * 11'(cdn_pkg::C_153);

	always_ff @(posedge clk) begin
		if (load7) begin
			mode_s7 <= mode_s6;
			num_s7  <= num_s6;
			ok_s7   <= ok_s6;
			dd2_s7  <= dd2_c7[7:0];
			mo_s7   <= (m_s6 < 4'd10) ? m_s6 + 4'd3 : m_s6 - 4'd9;
			yy_s7   <= (m_s6 < 4'd10) ? yy0_s6 : yy0_s6 + 14'd1;
		end
	end

	// Stage 8: day of month and the output word.
	logic [8:0]  ddp_c8;
	logic [17:0] prod_dd_c8;
	logic        date_c8;
	assign ddp_c8     = 9'(dd2_s7) + 9'd5;
	assign prod_dd_c8 = 18'(ddp_c8) * 18'(cdn_pkg::DIV5_M);
	assign date_c8    = (mode_s7 == cdn_pkg::MODE_TO_DATE) && ok_s7;

	always_ff @(posedge clk) begin
		if (load8) begin
			rsp_s8.day_number <= num_s7;
			rsp_s8.out_year   <= date_c8 ? yy_s7 : 14'd0;
			rsp_s8.out_month  <= date_c8 ? mo_s7 : 4'd0;
			rsp_s8.out_day    <= date_c8 ? prod_dd_c8[15:11] : 5'd0;
			rsp_s8.valid_res  <= ok_s7;
		end
	end

endmodule

FILE: sv/cdn_checker.sv
// Port-level assertions for the calendar day number converter and their binding.
module cdn_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input cdn_pkg::cdn_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result word changed or was dropped.");

	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("Result word present straight after reset.");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.valid_res |->
		rsp.out_year == 14'd0 && rsp.out_month == 4'd0 && rsp.out_day == 5'd0)
		else $error("Rejected word carries a date.");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.valid_res && rsp.out_month != 4'd0 |->
		rsp.out_month <= 4'd12 && rsp.out_day != 5'd0 && rsp.out_year != 14'd0
		&& rsp.day_number >= cdn_pkg::JD_FIRST && rsp.day_number <= cdn_pkg::JD_LAST)
		else $error("Converted date out of range for its day number.");

	a_number_sane: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.valid_res && rsp.out_month == 4'd0 |->
		rsp.day_number != 23'd0 && rsp.out_year == 14'd0 && rsp.out_day == 5'd0)
		else $error("Accepted date gave no day number.");

endmodule

bind calendar_day_number_converter cdn_checker u_cdn_checker (.*);

FILE: tb/sv/calendar_day_number_converter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the calendar day number converter.
module calendar_day_number_converter_tb;

	localparam int REQ_BITS = $bits(cdn_pkg::cdn_req_t);
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int unsigned MONTH_DAYS [12] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam cdn_pkg::cdn_rsp_t NO_DATE = '0;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_PERIODIC} stall_style_t;

	typedef struct {
		logic              mode;
		int unsigned       year;
		int unsigned       month;
		int unsigned       day;
		int unsigned       julian;
		bit                typed;
		cdn_pkg::cdn_rsp_t want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	cdn_pkg::cdn_req_t req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	cdn_pkg::cdn_rsp_t rsp;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	logic [13:0]       year_lo = cdn_pkg::MIN_YEAR_RST;
	logic [13:0]       year_hi = cdn_pkg::MAX_YEAR_RST;
	cdn_pkg::cdn_rsp_t pending_results [$];
	int unsigned       error_count = 0;
	int unsigned       burst_left = 0;
	stall_style_t      stall_style = STALL_NONE;
	int unsigned       style_left = 0;
	int unsigned       run_left = 0;
	bit                run_stalled = 1'b0;

	stim_row_t directed_rows [25] = '{
		'{cdn_pkg::MODE_TO_NUMBER, 2000, 1, 1, 0, 1'b1,
			'{23'd2451545, 14'd0, 4'd0, 5'd0, 1'b1}},
		'{cdn_pkg::MODE_TO_NUMBER, 1753, 1, 1, 8388607, 1'b0, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 1752, 12, 31, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 9999, 12, 31, 0, 1'b1,
			'{cdn_pkg::JD_LAST, 14'd0, 4'd0, 5'd0, 1'b1}},
		'{cdn_pkg::MODE_TO_NUMBER, 16383, 1, 1, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 0, 1, 1, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2024, 0, 10, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2024, 13, 10, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2024, 15, 31, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2024, 5, 0, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2023, 4, 31, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2023, 1, 31, 0, 1'b0, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2000, 2, 29, 0, 1'b0, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 1900, 2, 29, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2024, 2, 29, 0, 1'b0, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2023, 2, 29, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_NUMBER, 2100, 2, 28, 0, 1'b0, NO_DATE},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, cdn_pkg::JD_FIRST, 1'b1,
			'{cdn_pkg::JD_FIRST, 14'd1, 4'd1, 5'd1, 1'b1}},
		'{cdn_pkg::MODE_TO_DATE, 16383, 15, 31, cdn_pkg::JD_LAST, 1'b1,
			'{cdn_pkg::JD_LAST, 14'd9999, 4'd12, 5'd31, 1'b1}},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, cdn_pkg::JD_FIRST - 1, 1'b1,
			'{cdn_pkg::JD_FIRST - 23'd1, 14'd0, 4'd0, 5'd0, 1'b0}},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, cdn_pkg::JD_LAST + 1, 1'b1,
			'{cdn_pkg::JD_LAST + 23'd1, 14'd0, 4'd0, 5'd0, 1'b0}},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, 0, 1'b1, NO_DATE},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, 8388607, 1'b1,
			'{23'h7FFFFF, 14'd0, 4'd0, 5'd0, 1'b0}},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, 2451545, 1'b1,
			'{23'd2451545, 14'd2000, 4'd1, 5'd1, 1'b1}},
		'{cdn_pkg::MODE_TO_DATE, 0, 0, 0, 2460000, 1'b0, NO_DATE}
	};

	calendar_day_number_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned days_in(int unsigned y, int unsigned m);
		bit leap;
		leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
		return MONTH_DAYS[m - 1] + ((m == 2 && leap) ? 1 : 0);
	endfunction

	function automatic cdn_pkg::cdn_rsp_t convert_word(cdn_pkg::cdn_req_t w);
		cdn_pkg::cdn_rsp_t r;
		longint unsigned y, m, d, c, t, q, yr, mo, dy;
		r = '0;
		if (w.mode == cdn_pkg::MODE_TO_NUMBER) begin
			y = w.in_year;
			m = w.in_month;
			d = w.in_day;
			if (y != 0 && m >= 1 && m <= 12 && d != 0 && y >= year_lo && y <= year_hi
					&& d <= days_in(32'(y), 32'(m))) begin
				// The year is counted from March so that February falls last.
				if (m > 2) begin
					m -= 3;
				end else begin
					m += 9;
					y -= 1;
				end
				c = y / 100;
				t = y - 100 * c;
				r.day_number = 23'(((146097 * c) >> 2) + ((1461 * t) >> 2) + (153 * m + 2) / 5
					+ d + cdn_pkg::JD_EPOCH);
				r.valid_res = 1'b1;
			end
		end else begin
			r.day_number = w.in_julian;
			if (w.in_julian >= cdn_pkg::JD_FIRST && w.in_julian <= cdn_pkg::JD_LAST) begin
				t = w.in_julian;
				t = 4 * (t - cdn_pkg::JD_EPOCH) - 1;
				q = t / 146097;
				dy = (t - 146097 * q) >> 2;
				t = 4 * dy + 3;
				yr = t / 1461;
				dy = (t - 1461 * yr + 4) >> 2;
				t = 5 * dy - 3;
				mo = t / 153;
				dy = (t - 153 * mo + 5) / 5;
				yr = 100 * q + yr;
				if (mo < 10) begin
					mo += 3;
				end else begin
					mo -= 9;
					yr += 1;
				end
				r.out_year = 14'(yr);
				r.out_month = 4'(mo);
				r.out_day = 5'(dy);
				r.valid_res = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	task automatic send_word(cdn_pkg::cdn_req_t w, cdn_pkg::cdn_rsp_t want);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat (($urandom_range(9, 0) == 0) ? $urandom_range(20, 5) : $urandom_range(3, 1))
				@(posedge clk);
			burst_left = ($urandom_range(5, 0) == 0) ? $urandom_range(150, 60)
				: $urandom_range(12, 1);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_results.push_back(want);
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic idx, int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == cdn_pkg::REG_MIN_YEAR) begin
			year_lo = 14'(value);
		end else begin
			year_hi = 14'(value);
		end
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[13:0] != 14'(value))
			report_mismatch("register readback", prdata[13:0], value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(3, 0));
			style_left = $urandom_range(300, 40);
		end
		style_left--;
		case (stall_style)
			STALL_NONE: begin
				rsp_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				rsp_stall <= ($urandom_range(2, 0) == 0);
			end
			STALL_RUNS: begin
				if (run_left == 0) begin
					run_stalled = !run_stalled;
					run_left = $urandom_range(30, 1);
				end
				run_left--;
				rsp_stall <= run_stalled;
			end
			default: begin
				rsp_stall <= (style_left % 4 == 0);
			end
		endcase
	end

	always @(posedge clk) begin : check_results
		cdn_pkg::cdn_rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with none pending", rsp, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.day_number !== want.day_number)
					report_mismatch("day_number", rsp.day_number, want.day_number);
				if (rsp.out_year !== want.out_year)
					report_mismatch("out_year", rsp.out_year, want.out_year);
				if (rsp.out_month !== want.out_month)
					report_mismatch("out_month", rsp.out_month, want.out_month);
				if (rsp.out_day !== want.out_day)
					report_mismatch("out_day", rsp.out_day, want.out_day);
				if (rsp.valid_res !== want.valid_res)
					report_mismatch("valid_res", rsp.valid_res, want.valid_res);
			end
		end
	end

	initial begin : watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("FAIL calendar_day_number_converter");
		$finish;
	end

	initial begin : stimulus
		cdn_pkg::cdn_req_t w;
		int unsigned       y, m, kind;
		int unsigned       lo_set [PHASES];
		int unsigned       hi_set [PHASES];
		int unsigned       edge_years [5];
		lo_set = '{1, 0, 5000, 2000, 16383, 1753, 1, 1};
		hi_set = '{9999, 16383, 4000, 2000, 0, 9999, 9999, 9999};
		lo_set[6] = $urandom_range(9999, 1);
		hi_set[6] = $urandom_range(9999, 1);
		lo_set[7] = $urandom_range(9999, 1);
		hi_set[7] = $urandom_range(9999, 1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			w.mode = directed_rows[i].mode;
			w.in_year = 14'(directed_rows[i].year);
			w.in_month = 4'(directed_rows[i].month);
			w.in_day = 5'(directed_rows[i].day);
			w.in_julian = 23'(directed_rows[i].julian);
			send_word(w, directed_rows[i].typed ? directed_rows[i].want : convert_word(w));
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			write_register(cdn_pkg::REG_MIN_YEAR, lo_set[p]);
			write_register(cdn_pkg::REG_MAX_YEAR, hi_set[p]);
			// Dates on and just outside the year bounds, and year zero.
			edge_years = '{year_lo, year_hi, 0, (year_lo + 16383) % 16384, (year_hi + 1) % 16384};
			for (int k = 0; k < 5; k++) begin
				w = REQ_BITS'({$urandom, $urandom});
				w.mode = cdn_pkg::MODE_TO_NUMBER;
				w.in_year = 14'(edge_years[k]);
				w.in_month = (k % 2 == 1) ? 4'd12 : 4'd1;
				w.in_day = (k % 2 == 1) ? 5'd31 : 5'd1;
				send_word(w, convert_word(w));
			end
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if ($urandom_range(199, 0) == 0)
					wait_for_drain();
				w = REQ_BITS'({$urandom, $urandom});
				kind = $urandom_range(99, 0);
				if (kind < 45) begin
					w.mode = cdn_pkg::MODE_TO_NUMBER;
					if (kind < 35) begin
						y = (year_lo <= year_hi) ? $urandom_range(year_hi, year_lo)
							: $urandom_range(9999, 1);
						m = $urandom_range(12, 1);
						w.in_year = 14'(y);
						w.in_month = 4'(m);
						w.in_day = 5'((kind % 3 == 0) ? days_in(y, m)
							: $urandom_range(days_in(y, m), 1));
					end
				end else begin
					w.mode = cdn_pkg::MODE_TO_DATE;
					if (kind < 80) begin
						w.in_julian = 23'($urandom_range(cdn_pkg::JD_LAST, cdn_pkg::JD_FIRST));
					end else if (kind < 90) begin
						w.in_julian = 23'(((kind % 2 == 0) ? cdn_pkg::JD_FIRST : cdn_pkg::JD_LAST)
							+ $urandom_range(4, 0) - 2);
					end
				end
				send_word(w, convert_word(w));
			end
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS calendar_day_number_converter");
		end else begin
			$display("FAIL calendar_day_number_converter");
		end
		$finish;
	end

endmodule

FILE: calendar_day_number_converter.f
sv/cdn_pkg.sv
sv/calendar_day_number_converter.sv
sv/cdn_checker.sv
tb/sv/calendar_day_number_converter_tb.sv
